### src/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame checker package
// Shared beat types, status codes, register indexes and header constants.
// ----------------------------------------------------------------------------
package lpfc_pkg;

   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_FRAME_TYPE = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PAYLOAD_LENGTH = CSR_INDEX_WIDTH'(1);

   localparam logic [15:0] EXPECTED_FRAME_TYPE_RESET = 16'd1;
   localparam logic [31:0] MAX_PAYLOAD_LENGTH_RESET = 32'd1048576;
   localparam logic [15:0] SUPPORTED_VERSION = 16'd1;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_SHORT = 3'd1;
   localparam logic [2:0] STATUS_MAGIC = 3'd2;
   localparam logic [2:0] STATUS_VERSION = 3'd3;
   localparam logic [2:0] STATUS_TYPE = 3'd4;
   localparam logic [2:0] STATUS_LIMIT = 3'd5;
   localparam logic [2:0] STATUS_MISMATCH = 3'd6;

   localparam logic [7:0] MAGIC_BYTE0 = 8'h53;
   localparam logic [7:0] MAGIC_BYTE1 = 8'h47;
   localparam logic [7:0] MAGIC_BYTE2 = 8'h44;
   localparam logic [7:0] MAGIC_BYTE3 = 8'h31;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic        frame_end;
      logic [2:0]  frame_status;
      logic [15:0] frame_code;
   } rsp_type;

   typedef struct packed {
      logic [15:0] expected_frame_type;
      logic [31:0] max_payload_length;
   } cfg_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0: value = MAGIC_BYTE0;
         2'd1: value = MAGIC_BYTE1;
         2'd2: value = MAGIC_BYTE2;
         2'd3: value = MAGIC_BYTE3;
         default: value = MAGIC_BYTE0;
      endcase
      return value;
   endfunction

endpackage

### src/lpfc_csr.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame checker configuration registers
// Holds the expected frame type and the payload length limit.
// ----------------------------------------------------------------------------
module lpfc_csr (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [lpfc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [lpfc_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   output lpfc_pkg::cfg_type                        cfg
);

   lpfc_pkg::cfg_type cfg_ff;
   lpfc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lpfc_pkg::CSR_EXPECTED_FRAME_TYPE: begin
               cfg_in.expected_frame_type = csr_data[15:0];
            end
            lpfc_pkg::CSR_MAX_PAYLOAD_LENGTH: begin
               cfg_in.max_payload_length = csr_data[31:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_frame_type <= lpfc_pkg::EXPECTED_FRAME_TYPE_RESET;
         cfg_ff.max_payload_length <= lpfc_pkg::MAX_PAYLOAD_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/lpfc_parse.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame checker parser
// Counts packet bytes, captures header fields, gives one result per payload or last beat.
// ----------------------------------------------------------------------------
module lpfc_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  lpfc_pkg::req_type req_beat,
   input  lpfc_pkg::cfg_type cfg,
   output logic              res_valid,
   output lpfc_pkg::rsp_type res
);

   localparam logic [3:0] POS_VERSION_LO = 4'd4;
   localparam logic [3:0] POS_VERSION_HI = 4'd5;
   localparam logic [3:0] POS_TYPE_LO = 4'd6;
   localparam logic [3:0] POS_TYPE_HI = 4'd7;
   localparam logic [3:0] POS_CODE_LO = 4'd8;
   localparam logic [3:0] POS_CODE_HI = 4'd9;
   localparam logic [3:0] POS_LENGTH_B0 = 4'd12;
   localparam logic [3:0] POS_LENGTH_B1 = 4'd13;
   localparam logic [3:0] POS_LENGTH_B2 = 4'd14;
   localparam logic [3:0] POS_LENGTH_B3 = 4'd15;
   localparam logic [31:0] COUNT_MAX = '1;

   logic [31:0] byte_count_ff, byte_count_in;
   logic        magic_ok_ff, magic_ok_in;
   logic [15:0] version_ff, version_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] code_ff, code_in;
   logic [31:0] length_ff, length_in;

   logic        in_header;
   logic [3:0]  pos;
   logic [7:0]  b;
   logic [31:0] count_next;
   logic [32:0] expected_total;
   logic [2:0]  status;

   assign b = req_beat.data_byte;
   assign pos = byte_count_ff[3:0];
   assign in_header = (byte_count_ff[31:4] == '0);
   assign count_next = (byte_count_ff == COUNT_MAX) ? byte_count_ff
                                                    : byte_count_ff + 32'd1;

   always_comb begin
      magic_ok_in = magic_ok_ff;
      version_in = version_ff;
      type_in = type_ff;
      code_in = code_ff;
      length_in = length_ff;
      if (in_header) begin
         if (pos[3:2] == 2'b00) begin
            if (b != lpfc_pkg::magic_byte(pos[1:0])) begin
               magic_ok_in = 1'b0;
            end
         end
         case (pos)
            POS_VERSION_LO: version_in[7:0] = b;
            POS_VERSION_HI: version_in[15:8] = b;
            POS_TYPE_LO: type_in[7:0] = b;
            POS_TYPE_HI: type_in[15:8] = b;
            POS_CODE_LO: code_in[7:0] = b;
            POS_CODE_HI: code_in[15:8] = b;
            POS_LENGTH_B0: length_in[7:0] = b;
            POS_LENGTH_B1: length_in[15:8] = b;
            POS_LENGTH_B2: length_in[23:16] = b;
            POS_LENGTH_B3: length_in[31:24] = b;
            default: length_in = length_in;
         endcase
      end
   end

   assign expected_total = {1'b0, length_in} + 33'(lpfc_pkg::HEADER_BYTES);

   always_comb begin
      if (count_next < 32'(lpfc_pkg::HEADER_BYTES)) begin
         status = lpfc_pkg::STATUS_SHORT;
      end else if (!magic_ok_in) begin
         status = lpfc_pkg::STATUS_MAGIC;
      end else if (version_in != lpfc_pkg::SUPPORTED_VERSION) begin
         status = lpfc_pkg::STATUS_VERSION;
      end else if (type_in != cfg.expected_frame_type) begin
         status = lpfc_pkg::STATUS_TYPE;
      end else if (length_in > cfg.max_payload_length) begin
         status = lpfc_pkg::STATUS_LIMIT;
      end else if (count_next == COUNT_MAX) begin
         status = lpfc_pkg::STATUS_MISMATCH;
      end else if (expected_total != {1'b0, count_next}) begin
         status = lpfc_pkg::STATUS_MISMATCH;
      end else begin
         status = lpfc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      res_valid = accept && (!in_header || req_beat.last_byte);
      res.payload_byte = in_header ? 8'd0 : b;
      res.byte_valid = !in_header;
      res.frame_end = req_beat.last_byte;
      res.frame_status = req_beat.last_byte ? status : lpfc_pkg::STATUS_OK;
      res.frame_code = (req_beat.last_byte && status == lpfc_pkg::STATUS_OK) ? code_in
                                                                             : 16'd0;
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      if (accept) begin
         byte_count_in = req_beat.last_byte ? 32'd0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         magic_ok_ff <= 1'b1;
         version_ff <= '0;
         type_ff <= '0;
         code_ff <= '0;
         length_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         if (accept) begin
            if (req_beat.last_byte) begin
               magic_ok_ff <= 1'b1;
               version_ff <= '0;
               type_ff <= '0;
               code_ff <= '0;
               length_ff <= '0;
            end else begin
               magic_ok_ff <= magic_ok_in;
               version_ff <= version_in;
               type_ff <= type_in;
               code_ff <= code_in;
               length_ff <= length_in;
            end
         end
      end
   end

endmodule

### src/lpfc_obuf.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame checker output buffer
// Result register with a skid entry so the input side keeps flowing.
// ----------------------------------------------------------------------------
module lpfc_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpfc_pkg::rsp_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpfc_pkg::rsp_type rsp_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   lpfc_pkg::rsp_type main_data_ff, main_data_in;
   lpfc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign pop = main_valid_ff && !rsp_stall;
   assign full = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in = main_data_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

### src/length_prefixed_frame_checker.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame checker
// Checks the 16-byte header of byte-serial packets and forwards the payload.
//
// The req channel takes one packet byte per beat, with last_byte set on the
// final byte. Header beats give no result unless they are last; each payload
// beat gives one rsp beat with byte_valid set, and the last beat gives one
// rsp beat with frame_end, frame_status and frame_code. A non-ok status
// means the payload already forwarded for that packet must be dropped.
// The csr channel writes the expected frame type (index 0) and the payload
// length limit (index 1); csr_ready is always high and other indexes are
// ignored. Write registers only while the block is idle.
// The rsp beat of an accepted req beat is registered in the result register.
// One beat is taken every cycle while req_stall is low; the rate is set by
// the single result register stage. When rsp_stall holds, one more result
// goes to a skid entry; req_stall is high while it holds. Synchronous reset
// clears the packet state, empties both result entries and restores the
// register defaults (type 1, limit 1048576).
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lpfc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lpfc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lpfc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   lpfc_pkg::cfg_type cfg;
   lpfc_pkg::rsp_type res;
   logic              res_valid;
   logic              full;
   logic              accept;

   assign req_stall = full;
   assign accept = req_valid && !full;

   lpfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lpfc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_beat  (req_data),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   lpfc_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### bench/frame_beat_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame beat checker
// Watches the request, result and register channels of the frame checker,
// keeps its own copy of the header capture state and register values,
// predicts the result beat for each accepted payload or last byte and
// compares each accepted result beat field by field to the oldest prediction.
// ----------------------------------------------------------------------------
module frame_beat_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  lpfc_pkg::req_type                    req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  lpfc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [lpfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lpfc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                   error_count,
   output int                                   outstanding
);

   logic [15:0] want_type;
   logic [31:0] length_limit;

   logic [31:0] frame_bytes;
   logic        magic_seen_ok;
   logic [15:0] hdr_version;
   logic [15:0] hdr_type;
   logic [15:0] hdr_code;
   logic [31:0] hdr_length;

   lpfc_pkg::rsp_type expected_beats[$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   function automatic void clear_frame_state();
      frame_bytes = '0;
      magic_seen_ok = 1'b1;
      hdr_version = '0;
      hdr_type = '0;
      hdr_code = '0;
      hdr_length = '0;
   endfunction

   function automatic bit predict_frame_beat(input lpfc_pkg::req_type beat,
                                             output lpfc_pkg::rsp_type result);
      logic [31:0] pos;
      logic [7:0]  b;
      logic        in_payload;
      logic [2:0]  status;
      pos = frame_bytes;
      b = beat.data_byte;
      in_payload = (pos >= lpfc_pkg::HEADER_BYTES);
      result = '0;
      if (!in_payload) begin
         case (pos[3:0])
            4'd0: if (b != lpfc_pkg::MAGIC_BYTE0) magic_seen_ok = 1'b0;
            4'd1: if (b != lpfc_pkg::MAGIC_BYTE1) magic_seen_ok = 1'b0;
            4'd2: if (b != lpfc_pkg::MAGIC_BYTE2) magic_seen_ok = 1'b0;
            4'd3: if (b != lpfc_pkg::MAGIC_BYTE3) magic_seen_ok = 1'b0;
            4'd4: hdr_version[7:0] = b;
            4'd5: hdr_version[15:8] = b;
            4'd6: hdr_type[7:0] = b;
            4'd7: hdr_type[15:8] = b;
            4'd8: hdr_code[7:0] = b;
            4'd9: hdr_code[15:8] = b;
            4'd12: hdr_length[7:0] = b;
            4'd13: hdr_length[15:8] = b;
            4'd14: hdr_length[23:16] = b;
            4'd15: hdr_length[31:24] = b;
            default: ;
         endcase
      end
      if (frame_bytes != 32'hFFFF_FFFF) frame_bytes = frame_bytes + 32'd1;
      if (!beat.last_byte) begin
         if (!in_payload) return 1'b0;
         result.payload_byte = b;
         result.byte_valid = 1'b1;
         return 1'b1;
      end
      if (frame_bytes < lpfc_pkg::HEADER_BYTES) status = lpfc_pkg::STATUS_SHORT;
      else if (!magic_seen_ok) status = lpfc_pkg::STATUS_MAGIC;
      else if (hdr_version != lpfc_pkg::SUPPORTED_VERSION) status = lpfc_pkg::STATUS_VERSION;
      else if (hdr_type != want_type) status = lpfc_pkg::STATUS_TYPE;
      else if (hdr_length > length_limit) status = lpfc_pkg::STATUS_LIMIT;
      else if (frame_bytes == 32'hFFFF_FFFF) status = lpfc_pkg::STATUS_MISMATCH;
      else if ({1'b0, hdr_length} + 33'(lpfc_pkg::HEADER_BYTES) != {1'b0, frame_bytes})
         status = lpfc_pkg::STATUS_MISMATCH;
      else status = lpfc_pkg::STATUS_OK;
      result.payload_byte = in_payload ? b : 8'h00;
      result.byte_valid = in_payload;
      result.frame_end = 1'b1;
      result.frame_status = status;
      result.frame_code = (status == lpfc_pkg::STATUS_OK) ? hdr_code : 16'h0000;
      clear_frame_state();
      return 1'b1;
   endfunction

   function automatic string describe_beat(input lpfc_pkg::rsp_type beat);
      return $sformatf("byte %02h valid %0d end %0d status %0d code %04h",
                       beat.payload_byte, beat.byte_valid, beat.frame_end,
                       beat.frame_status, beat.frame_code);
   endfunction

   always @(posedge clock) begin
      lpfc_pkg::rsp_type predicted;
      lpfc_pkg::rsp_type oldest;
      bit                produced;
      if (reset) begin
         want_type = lpfc_pkg::EXPECTED_FRAME_TYPE_RESET;
         length_limit = lpfc_pkg::MAX_PAYLOAD_LENGTH_RESET;
         clear_frame_state();
         expected_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: result beat with nothing expected: %s", $realtime,
                           describe_beat(rsp_data));
               error_count++;
            end else begin
               oldest = expected_beats.pop_front();
               if ((rsp_data.payload_byte !== oldest.payload_byte) ||
                   (rsp_data.byte_valid !== oldest.byte_valid) ||
                   (rsp_data.frame_end !== oldest.frame_end) ||
                   (rsp_data.frame_status !== oldest.frame_status) ||
                   (rsp_data.frame_code !== oldest.frame_code)) begin
                  if (error_count < 10)
                     $display("%0t: result mismatch, expected %s, got %s", $realtime,
                              describe_beat(oldest), describe_beat(rsp_data));
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == lpfc_pkg::CSR_EXPECTED_FRAME_TYPE) want_type = csr_data[15:0];
            else if (csr_index == lpfc_pkg::CSR_MAX_PAYLOAD_LENGTH) length_limit = csr_data;
         end
         if (req_valid && !req_stall) begin
            produced = predict_frame_beat(req_data, predicted);
            if (produced) expected_beats = {expected_beats, predicted};
         end
      end
      outstanding <= expected_beats.size();
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame checker testbench top
// Drives byte-serial packets into the length-prefixed frame checker: a few
// directed packets first, then mostly well-formed frames with random content
// mixed with corrupted, truncated and noise packets, across several register
// settings and sender/receiver idling mixes. A separate checker module
// predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [lpfc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 8'hA5;
   localparam int unsigned BYTES_PER_SETTING = 322;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   lpfc_pkg::req_type                    req_data = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   lpfc_pkg::rsp_type                    rsp_data;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [lpfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [lpfc_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   int error_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   logic [15:0] cur_type = lpfc_pkg::EXPECTED_FRAME_TYPE_RESET;
   logic [31:0] cur_limit = lpfc_pkg::MAX_PAYLOAD_LENGTH_RESET;
   logic [7:0]  frame_q[$];

   always #6 clock = ~clock;

   length_prefixed_frame_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   frame_beat_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   task automatic append_byte(input logic [7:0] value);
      frame_q = {frame_q, value};
   endtask

   task automatic send_beat(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, last_byte: last};
      do @(posedge clock); while (!(req_valid && !req_stall));
      bytes_sent++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_q.size(); i++) send_beat(frame_q[i], i == frame_q.size() - 1);
      frames_sent++;
   endtask

   task automatic build_header(input logic [15:0] version, input logic [15:0] ftype,
                               input logic [15:0] code, input logic [15:0] rsvd,
                               input logic [31:0] length);
      append_byte(lpfc_pkg::MAGIC_BYTE0);
      append_byte(lpfc_pkg::MAGIC_BYTE1);
      append_byte(lpfc_pkg::MAGIC_BYTE2);
      append_byte(lpfc_pkg::MAGIC_BYTE3);
      append_byte(version[7:0]);
      append_byte(version[15:8]);
      append_byte(ftype[7:0]);
      append_byte(ftype[15:8]);
      append_byte(code[7:0]);
      append_byte(code[15:8]);
      append_byte(rsvd[7:0]);
      append_byte(rsvd[15:8]);
      append_byte(length[7:0]);
      append_byte(length[15:8]);
      append_byte(length[23:16]);
      append_byte(length[31:24]);
   endtask

   task automatic write_csr(input logic [lpfc_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [lpfc_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_setting(input logic write_regs, input logic [31:0] type_value,
                              input logic [31:0] limit_value);
      int          kind;
      int          plen;
      int          cut;
      int          stop_at;
      logic [31:0] len_field;
      logic [15:0] version;
      logic [15:0] ftype;
      wait_drained();
      if (write_regs) begin
         write_csr(lpfc_pkg::CSR_EXPECTED_FRAME_TYPE, type_value);
         write_csr(lpfc_pkg::CSR_MAX_PAYLOAD_LENGTH, limit_value);
         write_csr(CSR_UNUSED_INDEX, $urandom);
         csr_valid <= 1'b0;
      end
      cur_type = type_value[15:0];
      cur_limit = limit_value;
      stop_at = bytes_sent + BYTES_PER_SETTING;
      while (bytes_sent < stop_at) begin
         frame_q.delete();
         kind = $urandom_range(0, 99);
         version = lpfc_pkg::SUPPORTED_VERSION;
         ftype = cur_type;
         plen = $urandom_range(0, 20);
         if (plen > cur_limit) plen = cur_limit;
         len_field = plen;
         if (kind >= 65 && kind < 70) version = 16'($urandom_range(0, 65535));
         if (kind >= 70 && kind < 75) ftype = 16'($urandom_range(0, 65535));
         if (kind >= 75 && kind < 80) begin
            len_field = (cur_limit == 32'hFFFF_FFFF) ? $urandom
                                                    : cur_limit + 32'd1 + $urandom_range(0, 2);
            plen = $urandom_range(0, 8);
         end
         if (kind >= 80 && kind < 88) begin
            plen = $urandom_range(0, 24);
            if (plen == len_field) plen++;
         end
         build_header(version, ftype, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), len_field);
         if (kind >= 60 && kind < 65) begin
            cut = $urandom_range(0, 3);
            frame_q[cut] = frame_q[cut] ^ 8'($urandom_range(1, 255));
         end
         repeat (plen) append_byte(8'($urandom_range(0, 255)));
         if (kind >= 88 && kind < 95) begin
            cut = $urandom_range(1, 15);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
         end
         if (kind >= 95) begin
            frame_q.delete();
            repeat ($urandom_range(1, 30)) append_byte(8'($urandom_range(0, 255)));
         end
         send_frame();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      frame_q.delete();
      build_header(lpfc_pkg::SUPPORTED_VERSION, lpfc_pkg::EXPECTED_FRAME_TYPE_RESET,
                   16'hFFFF, 16'hFFFF, 32'd1);
      append_byte(8'hFF);
      send_frame();
      frame_q.delete();
      append_byte(8'h00);
      send_frame();
      frame_q.delete();
      append_byte(lpfc_pkg::MAGIC_BYTE0);
      append_byte(lpfc_pkg::MAGIC_BYTE1);
      append_byte(lpfc_pkg::MAGIC_BYTE2);
      append_byte(lpfc_pkg::MAGIC_BYTE3);
      send_frame();

      send_idle_pct = 25;
      recv_stall_pct = 59;
      run_setting(1'b0, 32'(lpfc_pkg::EXPECTED_FRAME_TYPE_RESET),
                  lpfc_pkg::MAX_PAYLOAD_LENGTH_RESET);
      run_setting(1'b1, 32'd2, 32'd0);
      send_idle_pct = 59;
      recv_stall_pct = 25;
      run_setting(1'b1, 32'hABCD_FFFF, 32'hFFFF_FFFF);
      run_setting(1'b1, 32'd0, 32'd12);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_setting(1'b1, 32'(lpfc_pkg::EXPECTED_FRAME_TYPE_RESET),
                  lpfc_pkg::MAX_PAYLOAD_LENGTH_RESET);
      run_setting(1'b1, 32'd2, 32'd20);
      wait_drained();

      $display("Sent %0d bytes in %0d packets under six register settings,",
               bytes_sent, frames_sent);
      $display("with good, corrupted, truncated and noise packets under mixed back-pressure.");
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Run did not finish in time.");
      $display("status: fail");
      $finish;
   end

endmodule
